@@ hw/rtl/tns_pkg.sv @@
// shared types, constants and helpers of the tone note sequencer
`default_nettype none

package tns_pkg;

	// width of the note length and gap down counter
	localparam int DURATION_BITS = 16;

	// configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_FREQUENCY = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAP_MS         = 2'd1;

	localparam logic [31:0] BASE_FREQUENCY_RESET = 32'd1193182;
	localparam logic [7:0]  GAP_MS_RESET         = 8'd20;

	// action codes of an incoming transaction
	localparam logic ACT_NOTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic [15:0] DIV_MAX = 16'hFFFF;

	// command queue between front and back
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = 2;
	localparam int CMDQ_CNT_W = 3;

	// one quotient bit per step
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = 5;

	typedef logic [DURATION_BITS-1:0] dur_t;

	typedef struct packed {
		logic        action;
		logic [15:0] frequency_hz;
		logic [15:0] duration_ms;
		logic        last_of_song;
	} tns_in_t;

	typedef struct packed {
		logic        gate_on;
		logic [15:0] tone_divisor;
		logic        busy_res;
		logic        accepted;
		logic        note_done;
		logic        song_done;
	} tns_out_t;

	typedef enum logic [1:0] {
		CMD_TONE,
		CMD_REST,
		CMD_TICK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] frequency_hz;
		dur_t        duration;
		logic        last_of_song;
	} cmd_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quotient;
	} div_rsp_t;

	localparam logic [32:0] DUR_MAX_W = (33'd1 << DURATION_BITS) - 33'd1;

	// saturate a 16 bit note length to the counter width
	function automatic dur_t dur_limit(input logic [15:0] dur);
		logic [32:0] v;
		v = {17'd0, dur};
		if (v > DUR_MAX_W) begin
			v = DUR_MAX_W;
		end
		return v[DURATION_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tns_front.sv @@
// front end: takes transactions, classifies them and queues them for the back end
`default_nettype none

module tns_front
	import tns_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	output logic         full,
	input  tns_in_t      req,
	output logic         cmd_valid,
	output cmd_t         cmd,
	input  wire logic    cmd_pop
);

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	cmd_t                  cls;
	logic                  wr_en;
	logic                  rd_en;

	always_comb begin
		cls.frequency_hz = req.frequency_hz;
		cls.duration     = dur_limit(req.duration_ms);
		cls.last_of_song = req.last_of_song;
		if (req.action == ACT_TICK) begin
			cls.kind = CMD_TICK;
		end else if (req.frequency_hz == 16'd0) begin
			cls.kind = CMD_REST;
		end else begin
			cls.kind = CMD_TONE;
		end
	end

	assign full      = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;
	assign cmd       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/tns_div.sv @@
// restoring divider for the tone divisor, one quotient bit per cycle, clamped result
`default_nettype none

module tns_div
	import tns_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  div_req_t  req,
	output div_rsp_t  rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0]          quo_q;
	logic [16:0]          rem_q;
	logic [15:0]          dvs_q;
	logic [16:0]          rem_sh;
	logic [16:0]          rem_nxt;
	logic                 q_bit;

	always_comb begin
		rem_sh = {rem_q[15:0], quo_q[31]};
		if (rem_sh >= {1'b0, dvs_q}) begin
			rem_nxt = rem_sh - {1'b0, dvs_q};
			q_bit   = 1'b1;
		end else begin
			rem_nxt = rem_sh;
			q_bit   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], q_bit};
			rem_q <= rem_nxt;
		end
	end

	// clamp to 1..65535
	always_comb begin
		rsp.done = done_q;
		if (quo_q == 32'd0) begin
			rsp.quotient = 16'd1;
		end else if (quo_q[31:16] != 16'd0) begin
			rsp.quotient = DIV_MAX;
		end else begin
			rsp.quotient = quo_q[15:0];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/tns_res_queue.sv @@
// two entry result queue in front of the result ports
`default_nettype none

module tns_res_queue
	import tns_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  tns_out_t  wr_item,
	output logic      full,
	output logic      empty,
	input  wire logic pop,
	output tns_out_t  rd_item
);

	tns_out_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push_ok;
	logic       pop_ok;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign push_ok = wr_en && !full;
	assign pop_ok  = pop && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push_ok, pop_ok})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/tns_back.sv @@
// back end: note and gap sequencing, configuration registers, divider control
`default_nettype none

module tns_back
	import tns_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]            cfg_data,
	input  wire logic                   cmd_valid,
	input  cmd_t                        cmd,
	output logic                        cmd_pop,
	output div_req_t                    div_req,
	input  div_rsp_t                    div_rsp,
	input  wire logic                   res_full,
	output logic                        res_push,
	output tns_out_t                    res_item
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PLAY,
		PH_GAP
	} phase_t;

	typedef enum logic {
		BK_WAIT,
		BK_DIV
	} bk_state_t;

	bk_state_t   bk_q, bk_d;
	phase_t      ph_q, ph_d, ph_cur;
	dur_t        rem_q, rem_d, rem_dec;
	logic [15:0] divr_q, divr_d;
	logic        gate_q, gate_d;
	logic        ending_q, ending_d;
	cmd_t        hold_q;
	logic [31:0] base_q;
	logic [7:0]  gap_q;

	logic        do_note;
	logic [15:0] note_div;
	logic        note_gate;
	dur_t        note_dur;
	logic        note_last;
	logic        acc, nd, sd;

	assign rem_dec = (rem_q != '0) ? rem_q - 1'b1 : rem_q;

	always_comb begin
		case (ph_q)
			PH_PLAY: ph_cur = PH_PLAY;
			PH_GAP:  ph_cur = PH_GAP;
			default: ph_cur = PH_IDLE;
		endcase
	end

	always_comb begin
		bk_d      = bk_q;
		ph_d      = ph_cur;
		rem_d     = rem_q;
		divr_d    = divr_q;
		gate_d    = gate_q;
		ending_d  = ending_q;
		acc       = 1'b0;
		nd        = 1'b0;
		sd        = 1'b0;
		do_note   = 1'b0;
		note_div  = 16'd0;
		note_gate = 1'b0;
		note_dur  = cmd.duration;
		note_last = cmd.last_of_song;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = base_q;
		div_req.divisor  = cmd.frequency_hz;

		case (bk_q)
			BK_WAIT: begin
				if (cmd_valid && !res_full) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						CMD_TICK: begin
							res_push = 1'b1;
							case (ph_cur)
								PH_PLAY: begin
									rem_d = rem_dec;
									if (rem_dec == '0) begin
										// duration over: close the gate, start the gap, or end the note at once when the gap is zero
										gate_d = 1'b0;
										rem_d  = DURATION_BITS'(gap_q);
										ph_d   = PH_GAP;
										if (gap_q == 8'd0) begin
											ph_d     = PH_IDLE;
											nd       = 1'b1;
											sd       = ending_q;
											ending_d = 1'b0;
										end
									end
								end
								PH_GAP: begin
									rem_d = rem_dec;
									if (rem_dec == '0) begin
										ph_d     = PH_IDLE;
										nd       = 1'b1;
										sd       = ending_q;
										ending_d = 1'b0;
									end
								end
								default: begin
								end
							endcase
						end
						CMD_REST: begin
							res_push = 1'b1;
							if (ph_cur == PH_IDLE) begin
								do_note = 1'b1;
							end
						end
						CMD_TONE: begin
							if (ph_cur == PH_IDLE) begin
								div_req.start = 1'b1;
								bk_d          = BK_DIV;
							end else begin
								res_push = 1'b1;
							end
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			BK_DIV: begin
				note_dur  = hold_q.duration;
				note_last = hold_q.last_of_song;
				if (div_rsp.done) begin
					do_note   = 1'b1;
					note_div  = div_rsp.quotient;
					note_gate = 1'b1;
					res_push  = 1'b1;
					bk_d      = BK_WAIT;
				end
			end
			default: begin
				bk_d = BK_WAIT;
			end
		endcase

		if (do_note) begin
			acc      = 1'b1;
			ending_d = note_last;
			divr_d   = note_div;
			gate_d   = note_gate;
			rem_d    = note_dur;
			ph_d     = PH_PLAY;
			if (note_dur == '0) begin
				gate_d = 1'b0;
				rem_d  = DURATION_BITS'(gap_q);
				ph_d   = PH_GAP;
				if (gap_q == 8'd0) begin
					ph_d     = PH_IDLE;
					nd       = 1'b1;
					sd       = note_last;
					ending_d = 1'b0;
				end
			end
		end

		res_item.gate_on      = gate_d;
		res_item.tone_divisor = divr_d;
		res_item.busy_res     = (ph_d != PH_IDLE);
		res_item.accepted     = acc;
		res_item.note_done    = nd;
		res_item.song_done    = sd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_q     <= BK_WAIT;
			ph_q     <= PH_IDLE;
			rem_q    <= '0;
			divr_q   <= '0;
			gate_q   <= 1'b0;
			ending_q <= 1'b0;
			hold_q   <= '0;
			base_q   <= BASE_FREQUENCY_RESET;
			gap_q    <= GAP_MS_RESET;
		end else begin
			bk_q <= bk_d;
			if (cmd_pop || res_push) begin
				ph_q     <= ph_d;
				rem_q    <= rem_d;
				divr_q   <= divr_d;
				gate_q   <= gate_d;
				ending_q <= ending_d;
			end
			if (div_req.start) begin
				hold_q <= cmd;
			end
			if (cfg_valid && cfg_index == REG_BASE_FREQUENCY) begin
				base_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == REG_GAP_MS) begin
				gap_q <= cfg_data[7:0];
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/tone_note_sequencer.sv @@
// top level of the tone note sequencer: front end, command queue, back end, result queue
`default_nettype none

// channel   | handshake              | payload
// ----------+------------------------+------------------------------------------
// request   | push / full            | req (tns_in_t): action, frequency, length
// result    | pop / empty            | res (tns_out_t): gate, divisor, status
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a tick, a rest or a refused note is handled in the back end wait state once queued
// a tone note waits for its quotient from the 32 step divider
// the front accepts into a four entry command queue while the back end is busy
// results wait in a two entry queue, the back end holds when it is full
// reset clears both queues, the note state and the registers to their defaults

module tone_note_sequencer
	import tns_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  tns_in_t                     req,
	output logic                        empty,
	input  wire logic                   pop,
	output tns_out_t                    res,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]            cfg_data
);

	// command path between front and back
	logic     cmd_valid;
	cmd_t     cmd;
	logic     cmd_pop;

	// divider handshake
	div_req_t div_req;
	div_rsp_t div_rsp;

	// result path
	logic     res_full;
	logic     res_push;
	tns_out_t res_wr;

	// registers are always writable; the user must make changes only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	tns_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	tns_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tns_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_item  (res_wr)
	);

	tns_res_queue u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_item (res_wr),
		.full    (res_full),
		.empty   (empty),
		.pop     (pop),
		.rd_item (res)
	);

	// a result transaction must never be dropped at a full result queue
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_push && res_full))
		else $error("result pushed into a full queue");

	// the back end only takes commands that exist
	a_no_cmd_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from an empty queue");

	// a sounding gate always has a programmed divisor
	a_gate_has_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_wr.gate_on) |-> (res_wr.tone_divisor != 16'd0))
		else $error("gate on with zero divisor");

	// song end only comes with a note end
	a_song_with_note: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_wr.song_done) |-> res_wr.note_done)
		else $error("song done without note done");

endmodule

`default_nettype wire

@@ tb/sv/tone_note_sequencer_checker.sv @@
// result checker of the tone note sequencer: shadow of the note state and field compare
module tone_note_sequencer_checker
	import tns_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   full,
	input  tns_in_t                req,
	input  logic                   empty,
	input  logic                   pop,
	input  tns_out_t               res,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data,
	output int unsigned            failures,
	output int unsigned            outstanding,
	output logic                   sequencer_busy,
	output int unsigned            results_seen,
	output int unsigned            songs_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_PLAY,
		SEQ_GAP
	} seq_phase_t;

	localparam logic [32:0] COUNT_CAP = (33'd1 << DURATION_BITS) - 33'd1;

	// shadow registers and note state
	logic [31:0] base_hz;
	logic [7:0]  gap_ticks;
	seq_phase_t  phase_q;
	logic [31:0] ticks_left;
	logic [15:0] divisor_q;
	logic        gate_q;
	logic        song_ending;

	tns_out_t    pending_results[$];
	int unsigned fail_count;
	int unsigned checked_count;
	int unsigned song_count;

	function automatic void close_note(inout tns_out_t r);
		phase_q = SEQ_IDLE;
		r.note_done = 1'b1;
		r.song_done = song_ending;
		song_ending = 1'b0;
	endfunction

	// gate off and silent gap; a zero gap ends the note at once
	function automatic void open_gap(inout tns_out_t r);
		gate_q = 1'b0;
		ticks_left = {24'd0, gap_ticks};
		phase_q = SEQ_GAP;
		if (ticks_left == 32'd0) begin
			close_note(r);
		end
	endfunction

	function automatic tns_out_t step_sequencer(input tns_in_t item);
		tns_out_t    r;
		logic [31:0] quotient;
		r = '0;
		if (item.action == ACT_NOTE) begin
			if (phase_q == SEQ_IDLE) begin
				r.accepted = 1'b1;
				song_ending = item.last_of_song;
				if (item.frequency_hz == 16'd0) begin
					divisor_q = 16'd0;
					gate_q = 1'b0;
				end else begin
					quotient = base_hz / {16'd0, item.frequency_hz};
					if (quotient == 32'd0) begin
						quotient = 32'd1;
					end else if (quotient > {16'd0, DIV_MAX}) begin
						quotient = {16'd0, DIV_MAX};
					end
					divisor_q = quotient[15:0];
					gate_q = 1'b1;
				end
				if ({17'd0, item.duration_ms} > COUNT_CAP) begin
					ticks_left = COUNT_CAP[31:0];
				end else begin
					ticks_left = {16'd0, item.duration_ms};
				end
				phase_q = SEQ_PLAY;
				if (ticks_left == 32'd0) begin
					open_gap(r);
				end
			end
		end else if (phase_q == SEQ_PLAY) begin
			if (ticks_left != 32'd0) begin
				ticks_left = ticks_left - 32'd1;
			end
			if (ticks_left == 32'd0) begin
				open_gap(r);
			end
		end else if (phase_q == SEQ_GAP) begin
			if (ticks_left != 32'd0) begin
				ticks_left = ticks_left - 32'd1;
			end
			if (ticks_left == 32'd0) begin
				close_note(r);
			end
		end
		r.gate_on = gate_q;
		r.tone_divisor = divisor_q;
		r.busy_res = (phase_q != SEQ_IDLE);
		if (r.song_done) begin
			song_count++;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tns_out_t want;
		if (!arst_n) begin
			base_hz = BASE_FREQUENCY_RESET;
			gap_ticks = GAP_MS_RESET;
			phase_q = SEQ_IDLE;
			ticks_left = 32'd0;
			divisor_q = 16'd0;
			gate_q = 1'b0;
			song_ending = 1'b0;
			pending_results.delete();
			fail_count = 0;
			checked_count = 0;
			song_count = 0;
		end else begin
			// result side first: a result never leaves on the edge its request enters
			if (pop && !empty) begin
				checked_count++;
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: result with nothing expected: %p", $realtime, res);
					end
				end else begin
					want = pending_results.pop_front();
					if (res !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: result %0d mismatch (expected/actual)", $realtime,
								checked_count);
							$display("  gate %b/%b divisor %0d/%0d busy %b/%b", want.gate_on,
								res.gate_on, want.tone_divisor, res.tone_divisor,
								want.busy_res, res.busy_res);
							$display("  accepted %b/%b note_done %b/%b song_done %b/%b",
								want.accepted, res.accepted, want.note_done, res.note_done,
								want.song_done, res.song_done);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BASE_FREQUENCY: base_hz = cfg_data;
					REG_GAP_MS:         gap_ticks = cfg_data[7:0];
					default: ;
				endcase
			end
			if (push && !full) begin
				pending_results.push_back(step_sequencer(req));
			end
		end
		failures       <= fail_count;
		outstanding    <= pending_results.size();
		sequencer_busy <= (phase_q != SEQ_IDLE);
		results_seen   <= checked_count;
		songs_seen     <= song_count;
	end

endmodule

@@ tb/sv/tone_note_sequencer_tb.sv @@
// testbench top of the tone note sequencer: clock, reset, stimulus and verdict
module tone_note_sequencer_tb;
	import tns_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// longest receiver hold-off, used to back the block up until it refuses input
	localparam int unsigned LONG_HOLD = 300;
	// cycles without any transaction before the run is declared hung
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	// a tone note may still wait for its divide, so this margin covers any straggler
	localparam int unsigned SETTLE_CYCLES = 100;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   push = 1'b0;
	logic                   full;
	tns_in_t                req = '0;
	logic                   empty;
	logic                   pop = 1'b0;
	tns_out_t               res;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_BASE_FREQUENCY;
	logic [31:0]            cfg_data = '0;

	int unsigned failures;
	int unsigned outstanding;
	logic        sequencer_busy;
	int unsigned results_seen;
	int unsigned songs_seen;

	// pacing knobs, the stall knob and hold requests are read by the pop process
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned holds_asked = 0;
	int unsigned holds_granted = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;

	// what the stimulus knows of the block: the gap it set and how much it sent
	int unsigned gap_now = GAP_MS_RESET;
	int unsigned sent = 0;

	tone_note_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tone_note_sequencer_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.req            (req),
		.empty          (empty),
		.pop            (pop),
		.res            (res),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.failures       (failures),
		.outstanding    (outstanding),
		.sequencer_busy (sequencer_busy),
		.results_seen   (results_seen),
		.songs_seen     (songs_seen)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: random stalls, or a long hold-off when the stimulus asks for one
	always @(posedge clk) begin
		if (hold_left != 0) begin
			pop <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_granted != holds_asked) begin
			pop <= 1'b0;
			hold_left <= LONG_HOLD;
			holds_granted <= holds_granted + 1;
		end else begin
			pop <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// watchdog: any transaction on any channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic tns_in_t note_item(input int unsigned freq, input int unsigned dur,
		input bit last);
		tns_in_t item;
		item.action = ACT_NOTE;
		item.frequency_hz = 16'(freq);
		item.duration_ms = 16'(dur);
		item.last_of_song = last;
		return item;
	endfunction

	// the note fields of a tick mean nothing, so they are left random
	function automatic tns_in_t tick_item();
		tns_in_t item;
		item.action = ACT_TICK;
		item.frequency_hz = 16'($urandom);
		item.duration_ms = 16'($urandom);
		item.last_of_song = 1'($urandom);
		return item;
	endfunction

	// stray transaction: either kind; a note keeps a short length so it can be drained
	function automatic tns_in_t stray_item();
		tns_in_t item;
		item = tick_item();
		item.action = 1'($urandom);
		if (item.action == ACT_NOTE) begin
			item.duration_ms = 16'($urandom_range(0, 15));
		end
		return item;
	endfunction

	// mostly audible notes, with rests, very low and full range frequencies mixed in
	function automatic int unsigned pick_frequency();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return $urandom_range(1, 64);
			2:       return $urandom_range(1, 65535);
			default: return $urandom_range(20, 20000);
		endcase
	endfunction

	// offer one request and hold it until the block takes it
	task automatic send(input tns_in_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req <= item;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		sent++;
	endtask

	// stop offering and wait for every expected result to come back
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	// tick the block back to idle so registers can be changed safely
	task automatic settle_idle();
		drain();
		while (sequencer_busy) begin
			send(tick_item());
			drain();
		end
	endtask

	// both registers in back to back transactions, valid stays high in between
	task automatic configure(input logic [31:0] base, input logic [7:0] gap);
		cfg_valid <= 1'b1;
		cfg_index <= REG_BASE_FREQUENCY;
		cfg_data <= base;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_index <= REG_GAP_MS;
		cfg_data <= {24'd0, gap};
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		gap_now = gap;
	endtask

	// a well formed song: each note followed by its length plus the gap in ticks,
	// sometimes cut short or run long, with the odd stray transaction in between
	task automatic send_song();
		int unsigned notes;
		int unsigned ticks;
		int unsigned n;
		int unsigned k;
		tns_in_t     item;
		notes = $urandom_range(1, 4);
		for (n = 0; n < notes; n++) begin
			item = note_item(pick_frequency(), $urandom_range(0, 10), n == notes - 1);
			send(item);
			ticks = item.duration_ms + gap_now;
			if ($urandom_range(0, 7) == 0) begin
				ticks = $urandom_range(0, ticks);
			end else if ($urandom_range(0, 7) == 0) begin
				ticks = ticks + $urandom_range(1, 3);
			end
			for (k = 0; k < ticks; k++) begin
				if ($urandom_range(0, 15) == 0) begin
					send(stray_item());
				end
				send(tick_item());
			end
		end
	endtask

	task automatic run_phase(input logic [31:0] base, input logic [7:0] gap,
		input int unsigned send_pct, input int unsigned recv_pct, input int unsigned budget,
		input bit long_hold, input bit mid_pause);
		int unsigned target;
		bit          paused;
		settle_idle();
		configure(base, gap);
		send_idle_pct = send_pct;
		stall_pct <= recv_pct;
		if (long_hold) begin
			holds_asked <= holds_asked + 1;
		end
		target = sent + budget;
		paused = 1'b0;
		while (sent < target) begin
			// one pause mid phase until the result side has caught up completely
			if (mid_pause && !paused && sent >= target - budget / 2) begin
				drain();
				paused = 1'b1;
			end
			send_song();
		end
	endtask

	initial begin
		int unsigned k;

		// reset is held asserted and released on a clock edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part with a zero gap so that finishing and taking a note can coincide
		configure(BASE_FREQUENCY_RESET, 8'd0);
		send(tick_item());                       // tick with nothing playing
		send(note_item(440, 2, 1'b0));
		send(note_item(1000, 5, 1'b1));          // refused, a note is still playing
		send(tick_item());
		send(tick_item());                       // note ends with no gap
		send(note_item(0, 1, 1'b1));             // rest, gate stays shut
		send(tick_item());
		send(note_item(1, 0, 1'b1));             // zero length, divisor clamps high
		send(note_item(65535, 1, 1'b0));
		send(tick_item());
		send(note_item(19, 0, 1'b0));
		settle_idle();

		// zero base frequency: the quotient clamps up to one
		configure(32'd0, 8'd2);
		send(note_item(1000, 0, 1'b1));
		send(tick_item());
		send(tick_item());
		settle_idle();

		// largest base frequency against the highest note
		configure(32'hFFFF_FFFF, 8'd2);
		send(note_item(65535, 1, 1'b1));
		repeat (3) send(tick_item());
		settle_idle();

		// long note ticked all the way out, a note of full length refused part way
		configure(BASE_FREQUENCY_RESET, 8'd2);
		send(note_item(440, 40, 1'b1));
		for (k = 0; k < 42; k++) begin
			if (k == 20) begin
				send(note_item(880, 65535, 1'b0));
			end
			send(tick_item());
		end

		// widest gap: one short note followed by the whole silent gap
		settle_idle();
		configure(BASE_FREQUENCY_RESET, 8'd255);
		send(note_item(440, 1, 1'b1));
		repeat (256) send(tick_item());

		// random songs under every pacing mode and a spread of register settings
		run_phase(BASE_FREQUENCY_RESET, 8'd0, 0, 0, 50, 1'b0, 1'b0);
		run_phase(32'hFFFF_FFFF, 8'd3, 46, 0, 50, 1'b0, 1'b1);
		run_phase($urandom, GAP_MS_RESET, 0, 46, 50, 1'b1, 1'b0);
		run_phase(32'd1000, 8'd1, 17, 17, 50, 1'b0, 1'b0);
		run_phase($urandom, 8'($urandom_range(4, 40)), 0, 46, 50, 1'b1, 1'b0);

		// let the last results out, then allow for anything arriving late
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d requests, %0d results compared, %0d songs played to the end",
			sent, results_seen, songs_seen);
		$display("base frequency from zero to all ones, gap 0 to 255, four pacing modes");
		if (failures == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d failures, %0d results missing", failures, outstanding);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
